FILE: src/bup_pkg.sv
// Shared types and constants of the bilinear 2x upscaler.
// No dependencies; used by every module of the block.
package bup_pkg;

    localparam int PIX_W   = 8;
    localparam int POS_W   = 11;
    localparam int CFG_W   = 12;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_CORNER_MODE  = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd400;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] left_cur;
        logic [PIX_W-1:0] left_above;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [3:0]       mask;
        logic             corner_mode;
    } t_entry;

endpackage

FILE: src/bup_front.sv
// Front part: accepts pixels, keeps the line store and neighbour registers,
// and classifies each pixel into the output blocks it completes. Uses bup_pkg.
module bup_front
    import bup_pkg::*;
#(
    parameter int CW = 11,
    parameter int RW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [PIX_W-1:0] i_pixel_in,
    input  logic [CW-1:0] i_last_col_idx,
    input  logic [RW-1:0] i_last_row_idx,
    input  logic          i_corner_mode,
    output logic          o_push,
    output t_entry        o_entry,
    input  logic          i_full
);

    localparam int DEPTH = 1 << CW;

    logic [PIX_W-1:0] r_line [DEPTH];

    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_px;
    logic [POS_W-1:0] r_s1_row;
    logic [POS_W-1:0] r_s1_col;
    logic [3:0]       r_s1_mask;
    logic             r_s1_cm;
    logic [PIX_W-1:0] r_above;
    logic [PIX_W-1:0] r_left_cur;
    logic [PIX_W-1:0] r_left_above;

    logic       acc;
    logic       adv;
    logic       last_col;
    logic       last_row;
    logic [3:0] n_mask;

    assign adv     = r_s1_valid && ((r_s1_mask == 4'd0) || !i_full);
    assign o_stall = r_s1_valid && !adv;
    assign acc     = i_valid && !o_stall;
    assign o_push  = r_s1_valid && (r_s1_mask != 4'd0) && !i_full;

    always_comb begin
        last_col  = r_col >= i_last_col_idx;
        last_row  = r_row >= i_last_row_idx;
        n_mask[0] = (r_row != '0) && (r_col != '0);
        n_mask[1] = (r_row != '0) && last_col;
        n_mask[2] = last_row && (r_col != '0);
        n_mask[3] = last_row && last_col;
        n_col     = r_col;
        n_row     = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_above      <= r_line[r_col];
            r_line[r_col] <= i_pixel_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_px   <= i_pixel_in;
            r_s1_row  <= POS_W'(r_row);
            r_s1_col  <= POS_W'(r_col);
            r_s1_mask <= n_mask;
            r_s1_cm   <= i_corner_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_s1_valid   <= 1'b0;
            r_left_cur   <= '0;
            r_left_above <= '0;
        end else begin
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_left_cur   <= r_s1_px;
                r_left_above <= r_above;
            end
        end
    end

    always_comb begin
        o_entry.px          = r_s1_px;
        o_entry.above       = r_above;
        o_entry.left_cur    = r_left_cur;
        o_entry.left_above  = r_left_above;
        o_entry.row         = r_s1_row;
        o_entry.col         = r_s1_col;
        o_entry.mask        = r_s1_mask;
        o_entry.corner_mode = r_s1_cm;
    end

endmodule

FILE: src/bup_fifo.sv
// Short queue of classified pixels between the front and back parts.
// Uses bup_pkg for the entry type and depth.
module bup_fifo
    import bup_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_empty
);

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;

    assign o_full  = r_count == (Q_PTR_W + 1)'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: src/bup_back.sv
// Back part: emits the output blocks of each queued pixel, one per cycle unless the output
// stalls, computing the truncated means into the output register. Uses bup_pkg.
module bup_back
    import bup_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_entry           i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PIX_W-1:0] o_top_left,
    output logic [PIX_W-1:0] o_top_right,
    output logic [PIX_W-1:0] o_bottom_left,
    output logic [PIX_W-1:0] o_bottom_right,
    output logic [POS_W-1:0] o_block_row,
    output logic [POS_W-1:0] o_block_col,
    output logic             o_frame_end
);

    localparam logic [1:0] BLK_ABOVE_LEFT  = 2'd0;
    localparam logic [1:0] BLK_ABOVE_EDGE  = 2'd1;
    localparam logic [1:0] BLK_BOTTOM_LEFT = 2'd2;
    localparam logic [1:0] BLK_CORNER      = 2'd3;

    logic             r_valid;
    logic [3:0]       r_taken;
    logic [PIX_W-1:0] r_tl, r_tr, r_bl, r_br;
    logic [POS_W-1:0] r_row, r_col;
    logic             r_end;

    logic             load;
    logic             last;
    logic [3:0]       rem;
    logic [3:0]       sel_bit;
    logic [1:0]       sel;
    logic [PIX_W-1:0] p, q, s, d;
    logic [POS_W-1:0] row, col;
    logic             fend;
    logic [PIX_W:0]   sum_pq, sum_ps;
    logic [PIX_W+1:0] sum_all;

    always_comb begin
        rem = i_head.mask & ~r_taken;
        if (rem[0]) begin
            sel = BLK_ABOVE_LEFT;
        end else if (rem[1]) begin
            sel = BLK_ABOVE_EDGE;
        end else if (rem[2]) begin
            sel = BLK_BOTTOM_LEFT;
        end else begin
            sel = BLK_CORNER;
        end
        sel_bit = 4'd1 << sel;
        last    = (rem & ~sel_bit) == 4'd0;
        load    = !i_empty && (!r_valid || !i_stall);
    end

    assign o_pop = load && last;

    always_comb begin
        p    = i_head.px;
        q    = i_head.px;
        s    = i_head.px;
        d    = i_head.px;
        row  = i_head.row;
        col  = i_head.col;
        fend = 1'b0;
        case (sel)
            BLK_ABOVE_LEFT: begin
                p   = i_head.left_above;
                q   = i_head.above;
                s   = i_head.left_cur;
                d   = i_head.px;
                row = i_head.row - 1'b1;
                col = i_head.col - 1'b1;
            end
            BLK_ABOVE_EDGE: begin
                p   = i_head.above;
                q   = i_head.above;
                s   = i_head.px;
                d   = i_head.corner_mode ? i_head.above : i_head.px;
                row = i_head.row - 1'b1;
            end
            BLK_BOTTOM_LEFT: begin
                p   = i_head.left_cur;
                q   = i_head.px;
                s   = i_head.left_cur;
                d   = i_head.corner_mode ? i_head.left_cur : i_head.px;
                col = i_head.col - 1'b1;
            end
            default: begin
                fend = 1'b1;
            end
        endcase
        sum_pq  = {1'b0, p} + {1'b0, q};
        sum_ps  = {1'b0, p} + {1'b0, s};
        sum_all = {2'b00, p} + {2'b00, q} + {2'b00, s} + {2'b00, d};
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tl  <= p;
            r_tr  <= sum_pq[PIX_W:1];
            r_bl  <= sum_ps[PIX_W:1];
            r_br  <= sum_all[PIX_W+1:2];
            r_row <= row;
            r_col <= col;
            r_end <= fend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_taken <= 4'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            if (load) begin
                r_taken <= last ? 4'd0 : (r_taken | sel_bit);
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_top_left     = r_tl;
    assign o_top_right    = r_tr;
    assign o_bottom_left  = r_bl;
    assign o_bottom_right = r_br;
    assign o_block_row    = r_row;
    assign o_block_col    = r_col;
    assign o_frame_end    = r_end;

endmodule

FILE: src/bilinear_2x_upscaler_unit.sv
// Top level of the bilinear 2x grey-scale upscaler with its configuration registers.
// Depends on bup_pkg, bup_front, bup_fifo and bup_back.
//
// The unit takes one 8-bit source pixel per cycle in raster order and returns 2x2 output
// blocks, one per cycle unless stalled, from one output register, with the block's source row and
// column. A block leaves once its right, lower and lower-right neighbours are in, so output
// trails input by about one row; the last column and the last row are flushed as they arrive.
// Most pixels release one block, a last-column or last-row pixel two, and the last pixel of a
// frame four, so the input accepts one pixel per cycle except when the four-entry queue in
// front of the output register fills in those bursts or under output stall. A pixel and its
// line store read are registered in the front stage before the queue; its first block then
// goes from the queue head to the output register. The line store needs no clearing after
// reset. The user must write sizes and corner mode while the unit is idle; it is not enforced.
module bilinear_2x_upscaler_unit
    import bup_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_pixel_in,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PIX_W-1:0] o_top_left,
    output logic [PIX_W-1:0] o_top_right,
    output logic [PIX_W-1:0] o_bottom_left,
    output logic [PIX_W-1:0] o_bottom_right,
    output logic [POS_W-1:0] o_block_row,
    output logic [POS_W-1:0] o_block_col,
    output logic             o_frame_end,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int CW = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic             r_corner_mode;

    logic [CW-1:0] last_col_idx;
    logic [RW-1:0] last_row_idx;

    logic   push, pop, full, empty;
    t_entry push_entry, head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_corner_mode  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_CORNER_MODE:  r_corner_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_frame_width < 12'd2) begin
            last_col_idx = CW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            last_col_idx = CW'(MAX_WIDTH - 1);
        end else begin
            last_col_idx = CW'(r_frame_width - 12'd1);
        end
        if (r_frame_height < 12'd2) begin
            last_row_idx = RW'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            last_row_idx = RW'(MAX_HEIGHT - 1);
        end else begin
            last_row_idx = RW'(r_frame_height - 12'd1);
        end
    end

    bup_front #(
        .CW (CW),
        .RW (RW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_in     (i_pixel_in),
        .i_last_col_idx (last_col_idx),
        .i_last_row_idx (last_row_idx),
        .i_corner_mode  (r_corner_mode),
        .o_push         (push),
        .o_entry        (push_entry),
        .i_full         (full)
    );

    bup_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    bup_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_top_left     (o_top_left),
        .o_top_right    (o_top_right),
        .o_bottom_left  (o_bottom_left),
        .o_bottom_right (o_bottom_right),
        .o_block_row    (o_block_row),
        .o_block_col    (o_block_col),
        .o_frame_end    (o_frame_end)
    );

endmodule

FILE: tb/bilinear_2x_upscaler_unit_test.sv
// Testbench for the bilinear 2x upscaler: directed and random pixel streams, with every
// 2x2 output block checked against a scoreboard that predicts the blocks from the stream.
// Depends on bup_pkg and bilinear_2x_upscaler_unit.
module bilinear_2x_upscaler_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bup_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int MAX_W         = 2048;
    localparam int MAX_H         = 2048;
    localparam int RANDOM_PIXELS = 100;
    localparam int WARM_COLS     = 128;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] top_left;
        logic [PIX_W-1:0] top_right;
        logic [PIX_W-1:0] bottom_left;
        logic [PIX_W-1:0] bottom_right;
        logic [POS_W-1:0] block_row;
        logic [POS_W-1:0] block_col;
        logic             frame_end;
    } t_upscale_block;

    class upscale_scoreboard;
        logic [PIX_W-1:0] line_mem [MAX_W];
        logic [PIX_W-1:0] left_cur;
        logic [PIX_W-1:0] left_up;
        int unsigned      row_pos;
        int unsigned      col_pos;
        int unsigned      width_reg;
        int unsigned      height_reg;
        bit               corner_reg;
        t_upscale_block   pending[$];
        int               err_count;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            left_cur   = '0;
            left_up    = '0;
            row_pos    = 0;
            col_pos    = 0;
            width_reg  = 32'(FRAME_WIDTH_RST);
            height_reg = 32'(FRAME_HEIGHT_RST);
            corner_reg = 1'b0;
            err_count  = 0;
        endfunction

        function void report(string msg);
            err_count++;
            if (err_count <= 100) begin
                $display("%0t ns: mismatch: %s", $time, msg);
            end
        endfunction

        function void write_reg(logic [1:0] index, logic [CFG_W-1:0] data);
            case (index)
                CFG_FRAME_WIDTH: begin
                    width_reg = 32'(data);
                end
                CFG_FRAME_HEIGHT: begin
                    height_reg = 32'(data);
                end
                CFG_CORNER_MODE: begin
                    corner_reg = data[0];
                end
                default: begin
                end
            endcase
        endfunction

        function int unsigned fit_size(int unsigned v, int unsigned limit);
            if (v < 2) return 2;
            if (v > limit) return limit;
            return v;
        endfunction

        function void add_block(input int unsigned p, q, s, d, row, col, input bit last);
            t_upscale_block b;
            b.top_left     = PIX_W'(p);
            b.top_right    = PIX_W'((p + q) >> 1);
            b.bottom_left  = PIX_W'((p + s) >> 1);
            b.bottom_right = PIX_W'((p + q + s + d) >> 2);
            b.block_row    = POS_W'(row);
            b.block_col    = POS_W'(col);
            b.frame_end    = last;
            pending.push_back(b);
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px);
            int unsigned w, h, c, r, up, lc, la, pv;
            bit last_col, last_row;
            w  = fit_size(width_reg, MAX_W);
            h  = fit_size(height_reg, MAX_H);
            c  = col_pos % MAX_W;
            r  = row_pos;
            last_col = (c >= w - 1);
            last_row = (r >= h - 1);
            up = 32'(line_mem[c]);
            lc = 32'(left_cur);
            la = 32'(left_up);
            pv = 32'(px);
            if (r >= 1) begin
                if (c >= 1) add_block(la, up, lc, pv, r - 1, c - 1, 1'b0);
                if (last_col) add_block(up, up, pv, corner_reg ? up : pv, r - 1, c, 1'b0);
            end
            if (last_row) begin
                if (c >= 1) add_block(lc, pv, lc, corner_reg ? lc : pv, r, c - 1, 1'b0);
                if (last_col) add_block(pv, pv, pv, pv, r, c, 1'b1);
            end
            line_mem[c] = px;
            left_up     = PIX_W'(up);
            left_cur    = px;
            if (last_col) begin
                col_pos = 0;
                row_pos = last_row ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void compare(string field, logic [15:0] got_v, logic [15:0] want_v,
                              t_upscale_block want);
            if (got_v !== want_v) begin
                report($sformatf("%s of block row %0d col %0d: got %0d, expected %0d",
                                 field, want.block_row, want.block_col, got_v, want_v));
            end
        endfunction

        function void check_block(t_upscale_block got);
            t_upscale_block want;
            if (pending.size() == 0) begin
                report($sformatf("block row %0d col %0d arrived with none expected",
                                 got.block_row, got.block_col));
                return;
            end
            want = pending.pop_front();
            compare("top_left", 16'(got.top_left), 16'(want.top_left), want);
            compare("top_right", 16'(got.top_right), 16'(want.top_right), want);
            compare("bottom_left", 16'(got.bottom_left), 16'(want.bottom_left), want);
            compare("bottom_right", 16'(got.bottom_right), 16'(want.bottom_right), want);
            compare("block_row", 16'(got.block_row), 16'(want.block_row), want);
            compare("block_col", 16'(got.block_col), 16'(want.block_col), want);
            compare("frame_end", 16'(got.frame_end), 16'(want.frame_end), want);
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [PIX_W-1:0] i_pixel_in;
    logic             o_valid;
    logic             i_stall;
    logic [PIX_W-1:0] o_top_left;
    logic [PIX_W-1:0] o_top_right;
    logic [PIX_W-1:0] o_bottom_left;
    logic [PIX_W-1:0] o_bottom_right;
    logic [POS_W-1:0] o_block_row;
    logic [POS_W-1:0] o_block_col;
    logic             o_frame_end;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    upscale_scoreboard sb;
    t_upscale_block    seen_block;
    int                send_gap_pct = 0;
    int                stall_pct = 0;
    int                hold_req = 0;
    int                hold_seen = 0;
    int                hold_left = 0;

    bilinear_2x_upscaler_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_in     (i_pixel_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_top_left     (o_top_left),
        .o_top_right    (o_top_right),
        .o_bottom_left  (o_bottom_left),
        .o_bottom_right (o_bottom_right),
        .o_block_row    (o_block_row),
        .o_block_col    (o_block_col),
        .o_frame_end    (o_frame_end),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial i_stall = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_block = {o_top_left, o_top_right, o_bottom_left, o_bottom_right,
                          o_block_row, o_block_col, o_frame_end};
            sb.check_block(seen_block);
        end
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        i_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end

    task automatic write_cfg(input logic [1:0] index, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(index, data);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] w, h, m, input logic [3:0] which);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (which[0]) write_cfg(CFG_FRAME_WIDTH, w);
        if (which[1]) write_cfg(CFG_FRAME_HEIGHT, h);
        if (which[2]) write_cfg(CFG_CORNER_MODE, m);
        if (which[3]) write_cfg(CFG_UNUSED, CFG_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pixel_in <= px;
        do @(posedge i_clk); while (o_stall);
        sb.note_pixel(px);
    endtask

    task automatic send_list(input logic [PIX_W-1:0] pix[$]);
        foreach (pix[i]) send_pixel(pix[i]);
        i_valid <= 1'b0;
    endtask

    task automatic send_random(input int count, input int hold_at);
        logic [PIX_W-1:0] px;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_req <= hold_req + 1;
            case ($urandom_range(7))
                0: px = '0;
                1: px = '1;
                default: px = PIX_W'($urandom);
            endcase
            send_pixel(px);
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        logic [PIX_W-1:0] run[$];
        logic [CFG_W-1:0] w, h;
        logic [3:0]       which;
        int               sent, phase, count, hold_at;
        sb = new();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_pixel_in  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apply_settings(12'd4, 12'd3, 12'd0, 4'b0111);
        run = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd128, 8'd1,
                8'd255, 8'd0, 8'd254, 8'd255};
        send_list(run);

        apply_settings(12'd1, 12'd0, 12'd1, 4'b0111);
        run = '{8'd255, 8'd0, 8'd0, 8'd255};
        send_list(run);

        // The frame shrinks under the row in progress, so the next pixel closes it.
        apply_settings(12'd4, 12'd4095, 12'd0, 4'b0111);
        run = '{8'd10, 8'd200, 8'd30, 8'd250, 8'd0, 8'd255};
        send_list(run);
        apply_settings(12'd2, 12'd0, 12'd0, 4'b0011);
        run = '{8'd77};
        send_list(run);

        // A long first row writes every line store entry that the random phases can reach.
        send_gap_pct = 17;
        stall_pct    = 17;
        apply_settings(CFG_W'(WARM_COLS), 12'd2, 12'd1, 4'b0111);
        send_random(WARM_COLS, -1);
        apply_settings(12'd2, 12'd2, 12'd0, 4'b0001);
        send_random(2, -1);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            case (phase % 4)
                0: begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1: begin
                    send_gap_pct = 66;
                    stall_pct    = 0;
                end
                2: begin
                    send_gap_pct = 0;
                    stall_pct    = 66;
                end
                default: begin
                    send_gap_pct = 17;
                    stall_pct    = 17;
                end
            endcase
            case ($urandom_range(15))
                0: w = 12'd0;
                1: w = 12'd1;
                2: w = 12'd4095;
                3: w = 12'd2048;
                default: w = CFG_W'($urandom_range(2, 9));
            endcase
            case ($urandom_range(15))
                0: h = 12'd0;
                1: h = 12'd4095;
                2: h = 12'd2048;
                default: h = CFG_W'($urandom_range(2, 6));
            endcase
            which   = 4'($urandom_range(1, 15));
            count   = $urandom_range(8, 20);
            hold_at = -1;
            if (phase == 4) begin
                w       = 12'd3;
                h       = 12'd4;
                which   = which | 4'b0011;
                count   = 40;
                hold_at = 6;
            end
            apply_settings(w, h, CFG_W'($urandom), which);
            send_random(count, hold_at);
            sent  += count;
            phase += 1;
        end

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.err_count == 0) begin
            $display("bilinear_2x_upscaler_unit_test: done, clean");
        end else begin
            $display("bilinear_2x_upscaler_unit_test: done, errors");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 400_000);
        $display("bilinear_2x_upscaler_unit_test: done, errors");
        $finish;
    end

endmodule
